// ===== rtl/icmp_echo_responder_unit_assert.svh =====
// Assertion macros for the module that checks itself.
// Each macro expects the signals clock and reset in scope.
`ifndef ICMP_ECHO_RESPONDER_UNIT_ASSERT_SVH
`define ICMP_ECHO_RESPONDER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define IECHO_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define IECHO_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/iecho_pkg.sv =====
`timescale 1ns / 1ps

package iecho_pkg;

   localparam int MAX_MESSAGE_BYTES = 2048;
   localparam int ADDR_W  = $clog2(MAX_MESSAGE_BYTES);
   localparam int COUNT_W = $clog2(MAX_MESSAGE_BYTES + 1);
   localparam int SUM_W   = COUNT_W + 15;

   localparam logic [7:0] ECHO_REQUEST_TYPE = 8'd8;
   localparam int         MIN_MESSAGE_BYTES = 8;

   localparam logic [2:0] STATUS_STORED   = 3'd0;
   localparam logic [2:0] STATUS_READY    = 3'd1;
   localparam logic [2:0] STATUS_NOT_ECHO = 3'd2;
   localparam logic [2:0] STATUS_SHORT    = 3'd3;
   localparam logic [2:0] STATUS_LONG     = 3'd4;
   localparam logic [2:0] STATUS_BYTE     = 3'd5;
   localparam logic [2:0] STATUS_EMPTY    = 3'd6;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_PULL = 1'b1;

   typedef struct packed {
      logic       restart;
      logic       drop;
      logic       add;
      logic       high_half;
      logic [7:0] data;
   } csum_ctl_type;

endpackage

// ===== rtl/icmp_echo_responder_unit.sv =====
`timescale 1ns / 1ps
// Channel   Handshake           Payload
// request   start, busy         req_op, req_data_byte, req_last_byte
// response  rsp_strobe          rsp_status, rsp_reply_byte, rsp_reply_last, rsp_reply_checksum
//
// A push beat is taken in ST_IDLE; its response appears in the following cycle.
// A last push that passes the checks goes on to ST_FOLD, which folds the sum.
// A pull beat passes through ST_READ, since the read of the store is registered.
// Reset is synchronous and needs no clearing pass; the store is only read where written.
// The receiver cannot stall; each response is shown for exactly one cycle.

module icmp_echo_responder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_reply_byte,
   output logic        rsp_reply_last,
   output logic [15:0] rsp_reply_checksum
);

`include "icmp_echo_responder_unit_assert.svh"

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_FOLD = 3'b010,
      ST_READ = 3'b100
   } state_type;

   localparam int CW = iecho_pkg::COUNT_W;
   localparam int AW = iecho_pkg::ADDR_W;

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rptr_ff, rptr_in;
   logic          ovf_ff, ovf_in;
   logic          ready_ff, ready_in;
   logic          echo_ff, echo_in;
   logic [15:0]   fcs_ff, fcs_in;

   logic          strobe_ff, strobe_in;
   logic [2:0]    status_ff, status_in;
   logic [7:0]    byte_ff, byte_in;
   logic          last_ff, last_in;
   logic [15:0]   csum_ff, csum_in;

   logic [7:0]    store_mem [iecho_pkg::MAX_MESSAGE_BYTES];
   logic [7:0]    rd_data_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [AW-1:0] mem_raddr;

   iecho_pkg::csum_ctl_type csum_ctl;
   logic [15:0]             checksum;

   logic          accept;
   logic [CW-1:0] base_count;
   logic [CW-1:0] pull_pos;

   iecho_csum u_csum (
      .clock    (clock),
      .reset    (reset),
      .ctl      (csum_ctl),
      .checksum (checksum)
   );

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      rptr_in    = rptr_ff;
      ovf_in     = ovf_ff;
      ready_in   = ready_ff;
      echo_in    = echo_ff;
      fcs_in     = fcs_ff;
      strobe_in  = 1'b0;
      status_in  = iecho_pkg::STATUS_STORED;
      byte_in    = '0;
      last_in    = 1'b0;
      csum_in    = '0;
      mem_we     = 1'b0;
      mem_waddr  = count_ff[AW-1:0];
      mem_raddr  = rptr_ff[AW-1:0];
      csum_ctl   = '0;
      csum_ctl.data = req_data_byte;
      base_count = ready_ff ? '0 : count_ff;
      pull_pos   = (rptr_ff >= count_ff) ? count_ff - CW'(1) : rptr_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept && req_op == iecho_pkg::OP_PUSH) begin
               strobe_in = 1'b1;
               if (ready_ff) begin
                  csum_ctl.restart = 1'b1;
                  ovf_in   = 1'b0;
                  ready_in = 1'b0;
                  rptr_in  = '0;
                  fcs_in   = '0;
               end
               if (base_count >= CW'(iecho_pkg::MAX_MESSAGE_BYTES)) begin
                  ovf_in    = 1'b1;
                  status_in = iecho_pkg::STATUS_LONG;
                  count_in  = base_count;
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = base_count[AW-1:0];
                  csum_ctl.add = (base_count != CW'(0)) && (base_count != CW'(2))
                     && (base_count != CW'(3));
                  csum_ctl.high_half = !base_count[0];
                  count_in = base_count + CW'(1);
                  if (base_count == '0) begin
                     echo_in = (req_data_byte == iecho_pkg::ECHO_REQUEST_TYPE);
                  end
               end
               if (req_last_byte) begin
                  if (ovf_in || count_in < CW'(iecho_pkg::MIN_MESSAGE_BYTES) || !echo_in)
                  begin
                     if (ovf_in) begin
                        status_in = iecho_pkg::STATUS_LONG;
                     end else if (count_in < CW'(iecho_pkg::MIN_MESSAGE_BYTES)) begin
                        status_in = iecho_pkg::STATUS_SHORT;
                     end else begin
                        status_in = iecho_pkg::STATUS_NOT_ECHO;
                     end
                     csum_ctl.drop = 1'b1;
                     count_in = '0;
                     ovf_in   = 1'b0;
                     ready_in = 1'b0;
                     rptr_in  = '0;
                     fcs_in   = '0;
                  end else begin
                     strobe_in = 1'b0;
                     state_in  = ST_FOLD;
                  end
               end
            end else if (accept) begin
               if (!ready_ff || count_ff == '0) begin
                  strobe_in = 1'b1;
                  status_in = iecho_pkg::STATUS_EMPTY;
               end else begin
                  rptr_in   = pull_pos;
                  mem_raddr = pull_pos[AW-1:0];
                  state_in  = ST_READ;
               end
            end
         end
         ST_FOLD: begin
            fcs_in    = checksum;
            ready_in  = 1'b1;
            rptr_in   = '0;
            strobe_in = 1'b1;
            status_in = iecho_pkg::STATUS_READY;
            csum_in   = checksum;
            state_in  = ST_IDLE;
         end
         ST_READ: begin
            strobe_in = 1'b1;
            status_in = iecho_pkg::STATUS_BYTE;
            if (rptr_ff == CW'(0)) begin
               byte_in = '0;
            end else if (rptr_ff == CW'(2)) begin
               byte_in = fcs_ff[15:8];
            end else if (rptr_ff == CW'(3)) begin
               byte_in = fcs_ff[7:0];
            end else begin
               byte_in = rd_data_ff;
            end
            if (rptr_ff + CW'(1) >= count_ff) begin
               last_in  = 1'b1;
               csum_ctl.drop = 1'b1;
               count_in = '0;
               ovf_in   = 1'b0;
               ready_in = 1'b0;
               rptr_in  = '0;
               fcs_in   = '0;
            end else begin
               rptr_in = rptr_ff + CW'(1);
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= req_data_byte;
      end
      rd_data_ff <= store_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         rptr_ff   <= '0;
         ovf_ff    <= 1'b0;
         ready_ff  <= 1'b0;
         echo_ff   <= 1'b0;
         fcs_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rptr_ff   <= rptr_in;
         ovf_ff    <= ovf_in;
         ready_ff  <= ready_in;
         echo_ff   <= echo_in;
         fcs_ff    <= fcs_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      byte_ff   <= byte_in;
      last_ff   <= last_in;
      csum_ff   <= csum_in;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_reply_byte     = byte_ff;
   assign rsp_reply_last     = last_ff;
   assign rsp_reply_checksum = csum_ff;

   `IECHO_ASSERT_NEXT(a_empty_pull, start && !busy && req_op == iecho_pkg::OP_PULL && !ready_ff,
      rsp_strobe && rsp_status == iecho_pkg::STATUS_EMPTY, "pull without reply not refused")
   `IECHO_ASSERT_NEXT(a_fold_ready, state_ff == ST_FOLD,
      ready_ff && rsp_strobe && rsp_status == iecho_pkg::STATUS_READY, "fold did not arm reply")
   `IECHO_ASSERT_NEXT(a_read_byte, state_ff == ST_READ,
      rsp_strobe && rsp_status == iecho_pkg::STATUS_BYTE, "read cycle gave no reply byte")
   `IECHO_ASSERT_NOW(a_count_bound, 1'b1,
      count_ff <= CW'(iecho_pkg::MAX_MESSAGE_BYTES), "byte count beyond the store")

endmodule

// ===== rtl/iecho_csum.sv =====
`timescale 1ns / 1ps

module iecho_csum (
   input  logic                   clock,
   input  logic                   reset,
   input  iecho_pkg::csum_ctl_type ctl,
   output logic [15:0]            checksum
);

   logic [iecho_pkg::SUM_W-1:0] sum_ff;
   logic [iecho_pkg::SUM_W-1:0] sum_in;
   logic [iecho_pkg::SUM_W-1:0] base_sum;
   logic [15:0]                 word;
   logic [16:0]                 fold_one;

   always_comb begin
      word     = ctl.high_half ? {ctl.data, 8'h00} : {8'h00, ctl.data};
      base_sum = ctl.restart ? '0 : sum_ff;
      if (ctl.drop) begin
         sum_in = '0;
      end else if (ctl.add) begin
         sum_in = base_sum + iecho_pkg::SUM_W'(word);
      end else begin
         sum_in = base_sum;
      end
   end

   // The high part is narrow, so a second carry can never spill out of bit 15.
   always_comb begin
      fold_one = {1'b0, sum_ff[15:0]} + 17'(sum_ff[iecho_pkg::SUM_W-1:16]);
      checksum = ~(fold_one[15:0] + 16'(fold_one[16]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

endmodule
